>>> design/lhd_pkg.sv
package lhd_pkg;

   localparam int FUNC_W      = 2;
   localparam int LINE_HASH_W = 64;
   localparam int KIND_W      = 2;
   localparam int IDX_W       = 6;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_OLD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_NEW = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]      func;
      logic [LINE_HASH_W-1:0] line_hash;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] range_kind;
      logic [IDX_W-1:0]  range_first;
      logic [IDX_W-1:0]  range_final;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CMP,
      ST_SRD,
      ST_SCMP,
      ST_FILL,
      ST_TADD,
      ST_TREM,
      ST_RRD,
      ST_RPROC,
      ST_ARD,
      ST_APROC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic rd_pair;
      logic match_step;
      logic search_init;
      logic rd_search;
      logic si_inc;
      logic miss_step;
      logic hit_step;
      logic fill_step;
      logic tail_add;
      logic tail_rem;
      logic rd_rem;
      logic rd_add;
      logic feed;
      logic close;
      logic to_add;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic oi_end;
      logic ni_end;
      logic same;
      logic si_end;
      logic fill_at;
      logic sc_zero;
      logic sc_at_new;
      logic push_ok;
      logic close_blocked;
      logic feed_blocked;
   } stat_type;

endpackage

>>> design/lhd_ram.sv
module lhd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lhd_ctrl.sv
module lhd_ctrl import lhd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_ready,
   input  stat_type          stat,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_func == FUNC_COMPUTE) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.oi_end)      state_in = ST_TADD;
            else if (stat.ni_end) state_in = ST_TREM;
            else                  state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = stat.same ? ST_CHECK : ST_SRD;
         end
         ST_SRD: begin
            state_in = stat.si_end ? ST_CHECK : ST_SCMP;
         end
         ST_SCMP: begin
            state_in = stat.same ? ST_FILL : ST_SRD;
         end
         ST_FILL: begin
            if (stat.fill_at) state_in = ST_CHECK;
         end
         ST_TADD: begin
            if (stat.ni_end) state_in = ST_RRD;
         end
         ST_TREM: begin
            if (stat.oi_end) state_in = ST_RRD;
         end
         ST_RRD: begin
            if (!stat.sc_zero)            state_in = ST_RPROC;
            else if (!stat.close_blocked) state_in = ST_ARD;
         end
         ST_RPROC: begin
            if (!stat.feed_blocked) state_in = ST_RRD;
         end
         ST_ARD: begin
            if (!stat.sc_at_new)          state_in = ST_APROC;
            else if (!stat.close_blocked) state_in = ST_FINISH;
         end
         ST_APROC: begin
            if (!stat.feed_blocked) state_in = ST_ARD;
         end
         ST_FINISH: begin
            if (stat.push_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid && req_func == FUNC_COMPUTE;
         end
         ST_CHECK: begin
            cmd.rd_pair = !stat.oi_end && !stat.ni_end;
         end
         ST_CMP: begin
            cmd.match_step  = stat.same;
            cmd.search_init = !stat.same;
         end
         ST_SRD: begin
            cmd.miss_step = stat.si_end;
            cmd.rd_search = !stat.si_end;
         end
         ST_SCMP: begin
            cmd.hit_step = stat.same;
            cmd.si_inc   = !stat.same;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
         end
         ST_TADD: begin
            cmd.tail_add = !stat.ni_end;
         end
         ST_TREM: begin
            cmd.tail_rem = !stat.oi_end;
         end
         ST_RRD: begin
            cmd.rd_rem = !stat.sc_zero;
            cmd.close  = stat.sc_zero && !stat.close_blocked;
            cmd.to_add = stat.sc_zero && !stat.close_blocked;
         end
         ST_RPROC: begin
            cmd.feed = !stat.feed_blocked;
         end
         ST_ARD: begin
            cmd.rd_add = !stat.sc_at_new;
            cmd.close  = stat.sc_at_new && !stat.close_blocked;
         end
         ST_APROC: begin
            cmd.feed = !stat.feed_blocked;
         end
         ST_FINISH: begin
            cmd.finish = stat.push_ok;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> design/lhd_dp.sv
module lhd_dp import lhd_pkg::*; #(
   parameter int MAX_LINES  = 64,
   parameter int HASH_WIDTH = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  req_type  req_payload,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_payload
);

   localparam int IW = $clog2(MAX_LINES);
   localparam int CW = $clog2(MAX_LINES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LINES);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   logic [CW-1:0]    old_cnt_ff, old_cnt_in;
   logic [CW-1:0]    new_cnt_ff, new_cnt_in;
   logic [CW-1:0]    oi_ff, oi_in;
   logic [CW-1:0]    ni_ff, ni_in;
   logic [CW-1:0]    si_ff, si_in;
   logic [CW-1:0]    sc_ff, sc_in;
   logic             phase_ff, phase_in;
   logic             run_active_ff, run_active_in;
   logic [IDX_W-1:0] run_a_ff, run_a_in;
   logic [IDX_W-1:0] run_b_ff, run_b_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic                  accept;
   logic                  load_old;
   logic                  load_new;
   logic [HASH_WIDTH-1:0] old_q;
   logic [HASH_WIDTH-1:0] new_q;
   logic [IW-1:0]         new_rd_addr;
   logic [CW-1:0]         sc_dec;
   logic                  rem_wr_en, rem_wr_data, rem_q;
   logic                  add_wr_en, add_wr_data, add_q;
   logic                  mark_bit;
   logic                  push_ok;
   logic                  do_close;
   logic [IDX_W-1:0]      idx;
   rsp_type               range;

   assign accept   = req_valid && req_ready;
   assign load_old = accept && req_payload.func == FUNC_LOAD_OLD && old_cnt_ff < CNT_MAX;
   assign load_new = accept && req_payload.func == FUNC_LOAD_NEW && new_cnt_ff < CNT_MAX;

   assign new_rd_addr = cmd.rd_search ? si_ff[IW-1:0] : ni_ff[IW-1:0];
   assign sc_dec      = sc_ff - CNT_ONE;

   assign rem_wr_en   = cmd.match_step || cmd.miss_step || cmd.hit_step || cmd.tail_rem;
   assign rem_wr_data = cmd.miss_step || cmd.tail_rem;
   assign add_wr_en   = cmd.match_step || cmd.miss_step || cmd.fill_step || cmd.tail_add;
   assign add_wr_data = cmd.miss_step || cmd.tail_add || (cmd.fill_step && ni_ff != si_ff);

   lhd_ram #(.WIDTH(HASH_WIDTH), .DEPTH(MAX_LINES)) u_old_ram (
      .clock   (clock),
      .wr_en   (load_old),
      .wr_addr (old_cnt_ff[IW-1:0]),
      .wr_data (req_payload.line_hash[HASH_WIDTH-1:0]),
      .rd_en   (cmd.rd_pair),
      .rd_addr (oi_ff[IW-1:0]),
      .rd_data (old_q)
   );

   lhd_ram #(.WIDTH(HASH_WIDTH), .DEPTH(MAX_LINES)) u_new_ram (
      .clock   (clock),
      .wr_en   (load_new),
      .wr_addr (new_cnt_ff[IW-1:0]),
      .wr_data (req_payload.line_hash[HASH_WIDTH-1:0]),
      .rd_en   (cmd.rd_pair || cmd.rd_search),
      .rd_addr (new_rd_addr),
      .rd_data (new_q)
   );

   lhd_ram #(.WIDTH(1), .DEPTH(MAX_LINES)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (oi_ff[IW-1:0]),
      .wr_data (rem_wr_data),
      .rd_en   (cmd.rd_rem),
      .rd_addr (sc_dec[IW-1:0]),
      .rd_data (rem_q)
   );

   lhd_ram #(.WIDTH(1), .DEPTH(MAX_LINES)) u_add_ram (
      .clock   (clock),
      .wr_en   (add_wr_en),
      .wr_addr (ni_ff[IW-1:0]),
      .wr_data (add_wr_data),
      .rd_en   (cmd.rd_add),
      .rd_addr (sc_ff[IW-1:0]),
      .rd_data (add_q)
   );

   assign mark_bit = phase_ff ? add_q : rem_q;
   assign push_ok  = !rsp_valid_ff || rsp_ready;
   assign idx      = IDX_W'(sc_ff);
   assign do_close = run_active_ff && (cmd.close || (cmd.feed && !mark_bit));

   always_comb begin
      range = '0;
      if (phase_ff) begin
         range.range_kind  = KIND_ADDED;
         range.range_first = run_a_ff;
         range.range_final = run_b_ff;
      end else begin
         range.range_kind  = KIND_REMOVED;
         range.range_first = run_b_ff;
         range.range_final = run_a_ff;
      end
   end

   always_comb begin
      stat.oi_end        = oi_ff >= old_cnt_ff;
      stat.ni_end        = ni_ff >= new_cnt_ff;
      stat.same          = old_q == new_q;
      stat.si_end        = si_ff >= new_cnt_ff;
      stat.fill_at       = ni_ff == si_ff;
      stat.sc_zero       = sc_ff == '0;
      stat.sc_at_new     = sc_ff == new_cnt_ff;
      stat.push_ok       = push_ok;
      stat.close_blocked = run_active_ff && pend_valid_ff && !push_ok;
      stat.feed_blocked  = !mark_bit && run_active_ff && pend_valid_ff && !push_ok;
   end

   always_comb begin
      old_cnt_in    = old_cnt_ff;
      new_cnt_in    = new_cnt_ff;
      oi_in         = oi_ff;
      ni_in         = ni_ff;
      si_in         = si_ff;
      sc_in         = sc_ff;
      phase_in      = phase_ff;
      run_active_in = run_active_ff;
      run_a_in      = run_a_ff;
      run_b_in      = run_b_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      if (load_old) old_cnt_in = old_cnt_ff + CNT_ONE;
      if (load_new) new_cnt_in = new_cnt_ff + CNT_ONE;

      if (cmd.start) begin
         oi_in         = '0;
         ni_in         = '0;
         sc_in         = old_cnt_ff;
         phase_in      = 1'b0;
         run_active_in = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (cmd.match_step || cmd.miss_step || cmd.hit_step || cmd.tail_rem) begin
         oi_in = oi_ff + CNT_ONE;
      end
      if (cmd.match_step || cmd.miss_step || cmd.fill_step || cmd.tail_add) begin
         ni_in = ni_ff + CNT_ONE;
      end
      if (cmd.search_init) si_in = ni_ff + CNT_ONE;
      if (cmd.si_inc)      si_in = si_ff + CNT_ONE;

      if (cmd.rd_rem) sc_in = sc_dec;
      if (cmd.feed && phase_ff) sc_in = sc_ff + CNT_ONE;

      if (cmd.feed && mark_bit) begin
         run_b_in = idx;
         if (!run_active_ff) begin
            run_a_in      = idx;
            run_active_in = 1'b1;
         end
      end

      if (do_close) begin
         run_active_in = 1'b0;
         pend_valid_in = 1'b1;
         pend_in       = range;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
         end
      end

      if (cmd.to_add) begin
         phase_in = 1'b1;
         sc_in    = '0;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_in = pend_ff;
         end else begin
            rsp_in             = '0;
            rsp_in.range_kind  = KIND_NONE;
         end
         rsp_in.last   = 1'b1;
         pend_valid_in = 1'b0;
         old_cnt_in    = '0;
         new_cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_cnt_ff    <= '0;
         new_cnt_ff    <= '0;
         oi_ff         <= '0;
         ni_ff         <= '0;
         si_ff         <= '0;
         sc_ff         <= '0;
         phase_ff      <= 1'b0;
         run_active_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         old_cnt_ff    <= old_cnt_in;
         new_cnt_ff    <= new_cnt_in;
         oi_ff         <= oi_in;
         ni_ff         <= ni_in;
         si_ff         <= si_in;
         sc_ff         <= sc_in;
         phase_ff      <= phase_in;
         run_active_ff <= run_active_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_a_ff <= run_a_in;
      run_b_ff <= run_b_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> design/line_hash_diff_ranges.sv
// Greedy line diff over two hash lists.
// req channel: func 0 appends line_hash to the old list, func 1 to the new
// list (a transfer past MAX_LINES entries is dropped), func 2 runs the diff
// and then empties both lists. Unused func codes are accepted and ignored.
// rsp channel: one transfer per merged range, removed ranges high to low,
// then added ranges low to high; a diff with no change gives one kind-2
// transfer. last marks the final transfer of a diff.
// Loads are accepted back to back while idle.
// A diff holds req_ready low until its final range is in the output
// register. The walk reads then compares each pair and each search probe,
// and steps through each skipped, tail or filled line; the range scan reads
// then processes each listed line, as the hash and mark RAMs each have a
// single read port. A range reaches the output register when the next
// range closes; the final one is moved there in the finish state.
// A stalled rsp_ready holds the scan; the output register plus one held
// range decouple the two sides. Reset empties both lists and clears the
// output; the hash RAMs need no clearing pass.
module line_hash_diff_ranges import lhd_pkg::*; #(
   parameter int MAX_LINES  = 64,
   parameter int HASH_WIDTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type  cmd;
   stat_type stat;

   lhd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_payload.func),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lhd_dp #(.MAX_LINES(MAX_LINES), .HASH_WIDTH(HASH_WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> design/lhd_checker.sv
module lhd_checker import lhd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.func == FUNC_COMPUTE |=> !req_ready)
      else $error("req accepted right after a diff transfer");

   a_none_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.range_kind == KIND_NONE |->
         rsp_payload.last && rsp_payload.range_first == '0 &&
         rsp_payload.range_final == '0)
      else $error("malformed no-change transfer");

endmodule

bind line_hash_diff_ranges lhd_checker u_lhd_checker (.*);

>>> test/tb_line_hash_diff_ranges.sv
module tb_line_hash_diff_ranges;
   timeunit 1ns;
   timeprecision 1ps;

   import lhd_pkg::*;

   localparam int LINES       = 64;
   localparam int LIMIT       = 1_000_000;
   localparam int HOLD_CYCLES = 600;
   localparam int ITEM_TARGET = 420;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   localparam int STYLE_POOL  = 0;
   localparam int STYLE_EDIT  = 1;
   localparam int STYLE_SAME  = 2;
   localparam int STYLE_NOISE = 3;

   class range_ledger;
      logic [LINE_HASH_W-1:0] old_list[LINES];
      logic [LINE_HASH_W-1:0] new_list[LINES];
      int old_len, new_len;
      rsp_type batch[$];
      rsp_type ranges_due[$];
      int failures, diffs, loads, ignored, transfers, widest;

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         failures++;
      endtask

      function void add_range(logic [KIND_W-1:0] kind, int lo, int hi);
         rsp_type r;
         r.range_kind  = kind;
         r.range_first = IDX_W'(lo);
         r.range_final = IDX_W'(hi);
         r.last        = 1'b0;
         batch.insert(batch.size(), r);
      endfunction

      function void predict_ranges();
         logic [LINES-1:0] gone, fresh;
         int oi, ni, hit, i, hi;
         rsp_type r;
         gone = '0;
         fresh = '0;
         oi = 0;
         ni = 0;
         batch.delete();
         while (oi < old_len || ni < new_len) begin
            if (oi >= old_len) begin
               fresh[ni] = 1'b1;
               ni++;
            end else if (ni >= new_len) begin
               gone[oi] = 1'b1;
               oi++;
            end else if (old_list[oi] == new_list[ni]) begin
               oi++;
               ni++;
            end else begin
               hit = -1;
               for (i = ni; i < new_len; i++)
                  if (hit < 0 && new_list[i] == old_list[oi]) hit = i;
               if (hit >= 0) begin
                  for (i = ni; i < hit; i++) fresh[i] = 1'b1;
                  ni = hit + 1;
               end else begin
                  fresh[ni] = 1'b1;
                  gone[oi] = 1'b1;
                  ni++;
               end
               oi++;
            end
         end
         // removed high to low, then added low to high
         i = LINES - 1;
         while (i >= 0) begin
            if (gone[i]) begin
               hi = i;
               while (i > 0 && gone[i-1]) i--;
               add_range(KIND_REMOVED, i, hi);
            end
            i--;
         end
         i = 0;
         while (i < LINES) begin
            if (fresh[i]) begin
               hi = i;
               while (i + 1 < LINES && fresh[i+1]) i++;
               add_range(KIND_ADDED, hi, i);
            end
            i++;
         end
         if (batch.size() == 0) add_range(KIND_NONE, 0, 0);
         r = batch.pop_back();
         r.last = 1'b1;
         batch.insert(batch.size(), r);
         if (batch.size() > widest) widest = batch.size();
         foreach (batch[j]) ranges_due.insert(ranges_due.size(), batch[j]);
         old_len = 0;
         new_len = 0;
         diffs++;
      endfunction

      function void note_request(req_type q);
         case (q.func)
            FUNC_LOAD_OLD: begin
               loads++;
               if (old_len < LINES) begin
                  old_list[old_len] = q.line_hash;
                  old_len++;
               end
            end
            FUNC_LOAD_NEW: begin
               loads++;
               if (new_len < LINES) begin
                  new_list[new_len] = q.line_hash;
                  new_len++;
               end
            end
            FUNC_COMPUTE: predict_ranges();
            default: ignored++;
         endcase
      endfunction

      task check_range(rsp_type got);
         rsp_type want;
         transfers++;
         if (ranges_due.size() == 0) begin
            report($sformatf("unexpected range kind %0d %0d..%0d last %0d", got.range_kind,
                             got.range_first, got.range_final, got.last));
            return;
         end
         want = ranges_due.pop_front();
         if (got.range_kind !== want.range_kind)
            report($sformatf("range_kind %0d, want %0d", got.range_kind, want.range_kind));
         if (got.range_first !== want.range_first)
            report($sformatf("range_first %0d, want %0d", got.range_first, want.range_first));
         if (got.range_final !== want.range_final)
            report($sformatf("range_final %0d, want %0d", got.range_final, want.range_final));
         if (got.last !== want.last)
            report($sformatf("last %0d, want %0d", got.last, want.last));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   bit calm = 1'b0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int cycles = 0;
   int items_sent = 0;

   range_ledger ledger = new();

   line_hash_diff_ranges #(
      .MAX_LINES(LINES),
      .HASH_WIDTH(LINE_HASH_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off, a calm window
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.check_range(rsp_payload);
      if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && (calm || $urandom_range(99) >= 26);
      end
   end

   function automatic logic [LINE_HASH_W-1:0] rand_hash();
      return {$urandom, $urandom};
   endfunction

   task automatic send(logic [FUNC_W-1:0] f, logic [LINE_HASH_W-1:0] h);
      req_type p;
      p.func = f;
      p.line_hash = h;
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_request(p);
      if (f != FUNC_SPARE) items_sent++;
   endtask

   task automatic run_diff(int n_old, int n_new, int style);
      logic [LINE_HASH_W-1:0] pool[4];
      logic [LINE_HASH_W-1:0] olds[$];
      logic [LINE_HASH_W-1:0] news[$];
      int k, oi, ni;
      foreach (pool[j]) pool[j] = rand_hash();
      for (k = 0; k < n_old; k++)
         olds.insert(olds.size(),
                     style == STYLE_POOL ? pool[$urandom_range(3)] : rand_hash());
      case (style)
         STYLE_SAME: news = olds;
         STYLE_EDIT: begin
            foreach (olds[j]) begin
               case ($urandom_range(7))
                  0: ;
                  1: begin
                     news.insert(news.size(), rand_hash());
                     news.insert(news.size(), olds[j]);
                  end
                  2: news.insert(news.size(), rand_hash());
                  default: news.insert(news.size(), olds[j]);
               endcase
            end
         end
         default: begin
            for (k = 0; k < n_new; k++)
               news.insert(news.size(),
                           style == STYLE_POOL ? pool[$urandom_range(3)] : rand_hash());
         end
      endcase
      oi = 0;
      ni = 0;
      while (oi < olds.size() || ni < news.size()) begin
         if ($urandom_range(19) == 0) begin
            send(FUNC_SPARE, rand_hash());
         end else if (ni >= news.size() || (oi < olds.size() && $urandom_range(1))) begin
            send(FUNC_LOAD_OLD, olds[oi]);
            oi++;
         end else begin
            send(FUNC_LOAD_NEW, news[ni]);
            ni++;
         end
      end
      send(FUNC_COMPUTE, rand_hash());
   endtask

   function automatic int pick_len();
      if ($urandom_range(11) == 0) return $urandom_range(30, 66);
      return $urandom_range(0, 10);
   endfunction

   initial begin
      int diff_no;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty lists
      send(FUNC_COMPUTE, '1);
      // identical one-line lists
      send(FUNC_LOAD_OLD, '1);
      send(FUNC_LOAD_NEW, '1);
      send(FUNC_COMPUTE, '0);
      // old only, with an unused code in between
      send(FUNC_LOAD_OLD, '0);
      send(FUNC_SPARE, '1);
      send(FUNC_COMPUTE, '0);
      // new only
      send(FUNC_LOAD_NEW, '1);
      send(FUNC_LOAD_NEW, '0);
      send(FUNC_COMPUTE, '0);
      // search hit: one line inserted at the front
      send(FUNC_LOAD_OLD, 64'hA5A5_A5A5_A5A5_A5A5);
      send(FUNC_LOAD_OLD, 64'h5A5A_5A5A_5A5A_5A5A);
      send(FUNC_LOAD_OLD, 64'h0123_4567_89AB_CDEF);
      send(FUNC_LOAD_NEW, 64'hFEDC_BA98_7654_3210);
      send(FUNC_LOAD_NEW, 64'hA5A5_A5A5_A5A5_A5A5);
      send(FUNC_LOAD_NEW, 64'h5A5A_5A5A_5A5A_5A5A);
      send(FUNC_LOAD_NEW, 64'h0123_4567_89AB_CDEF);
      send(FUNC_COMPUTE, '1);
      // search miss on every line
      send(FUNC_LOAD_OLD, 64'h8000_0000_0000_0000);
      send(FUNC_LOAD_OLD, 64'h0000_0000_0000_0001);
      send(FUNC_LOAD_NEW, 64'h7FFF_FFFF_FFFF_FFFF);
      send(FUNC_LOAD_NEW, 64'hFFFF_FFFF_FFFF_FFFE);
      send(FUNC_COMPUTE, '0);

      // both lists past capacity, then hold the receiver so the input stalls
      run_diff(66, 66, STYLE_POOL);
      hold_go <= 1'b1;

      diff_no = 0;
      while (items_sent < ITEM_TARGET) begin
         calm <= (diff_no >= 6 && diff_no < 12);
         case ($urandom_range(9))
            0, 1, 2: run_diff(pick_len(), pick_len(), STYLE_POOL);
            3:       run_diff(pick_len(), 0, STYLE_SAME);
            4:       run_diff(pick_len(), pick_len(), STYLE_NOISE);
            default: run_diff(pick_len(), 0, STYLE_EDIT);
         endcase
         diff_no++;
      end
      calm <= 1'b0;
      req_valid <= 1'b0;

      while (ledger.ranges_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d hash loads, %0d ignored requests, %0d diffs", ledger.loads,
               ledger.ignored, ledger.diffs);
      $display("%0d ranges checked, up to %0d from one diff, %0d cycles",
               ledger.transfers, ledger.widest, cycles);
      if (ledger.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
